### sv/rrts_pkg.sv
package rrts_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int CMD_W      = 2;
    localparam int PID_W      = 16;
    localparam int RS_W       = 2;
    localparam int SP_W       = 32;
    localparam int STATUS_W   = 3;
    localparam int CUR_SLOT_W = 6;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd3;

    localparam logic [RS_W-1:0] RS_READY   = 2'd0;
    localparam logic [RS_W-1:0] RS_RUNNING = 2'd1;
    localparam logic [RS_W-1:0] RS_BLOCKED = 2'd2;
    localparam logic [RS_W-1:0] RS_UNKNOWN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TASK   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd4;

    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              pid_we;
        logic [SLOT_W-1:0] pid_addr;
        logic [PID_W-1:0]  pid_data;
        logic              rs_we;
        logic [SLOT_W-1:0] rs_addr;
        logic [RS_W-1:0]   rs_data;
        logic              sp_we;
        logic [SLOT_W-1:0] sp_addr;
        logic [SP_W-1:0]   sp_data;
    } t_ram_req;

    function automatic logic [RS_W-1:0] clean_state(input logic [RS_W-1:0] s);
        return (s == RS_UNKNOWN) ? RS_BLOCKED : s;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(NUM_SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

endpackage

### sv/rrts_if.sv
interface rrts_in_if import rrts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] task_pid;
    logic [RS_W-1:0]  task_state;
    logic [SP_W-1:0]  stack_ptr;

    modport source (output valid, cmd, task_pid, task_state, stack_ptr, input ready);
    modport sink   (input valid, cmd, task_pid, task_state, stack_ptr, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SP_W-1:0]       resume_sp;
    logic [PID_W-1:0]      current_pid;
    logic [CUR_SLOT_W-1:0] current_slot;

    modport source (output valid, status, resume_sp, current_pid, current_slot, input ready);
    modport sink   (input valid, status, resume_sp, current_pid, current_slot, output ready);
endinterface

### sv/rrts_ram.sv
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/rrts_ctrl.sv
module rrts_ctrl import rrts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_paused,
    rrts_in_if.sink           i_item,
    rrts_out_if.source        o_res,
    output t_ram_req          o_ram,
    input  logic [PID_W-1:0]  i_rd_pid,
    input  logic [RS_W-1:0]   i_rd_rs,
    input  logic [SP_W-1:0]   i_rd_sp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_FIND,
        S_PREV,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_valid, n_valid;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic [PID_W-1:0]      r_run_pid, n_run_pid;
    logic                  r_halted, n_halted;
    logic [SLOT_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]      r_left, n_left;
    logic                  r_dv, n_dv;
    logic [SLOT_W-1:0]     r_daddr, n_daddr;
    logic                  r_dlast, n_dlast;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic [RS_W-1:0]       r_rs, n_rs;
    logic [SP_W-1:0]       r_sp, n_sp;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [SP_W-1:0]       r_res_sp, n_res_sp;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [SP_W-1:0]       r_out_sp, n_out_sp;
    logic [PID_W-1:0]      r_out_pid, n_out_pid;
    logic [CUR_SLOT_W-1:0] r_out_slot, n_out_slot;
    t_ram_req              ram;
    logic                  hit;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cur        = r_cur;
        n_run_pid    = r_run_pid;
        n_halted     = r_halted;
        n_addr       = r_addr;
        n_left       = r_left;
        n_dv         = 1'b0;
        n_daddr      = r_daddr;
        n_dlast      = r_dlast;
        n_cmd        = r_cmd;
        n_pid        = r_pid;
        n_rs         = r_rs;
        n_sp         = r_sp;
        n_res_status = r_res_status;
        n_res_sp     = r_res_sp;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_sp     = r_out_sp;
        n_out_pid    = r_out_pid;
        n_out_slot   = r_out_slot;
        hit          = 1'b0;

        ram          = '0;
        ram.rd_addr  = r_addr;
        ram.pid_addr = r_addr;
        ram.pid_data = r_pid;
        ram.rs_addr  = r_daddr;
        ram.rs_data  = RS_RUNNING;
        ram.sp_addr  = r_addr;
        ram.sp_data  = r_sp;

        // one slot address issued per cycle, its data checked in the next cycle
        if ((r_state == S_FIND || r_state == S_PREV || r_state == S_SCAN) && r_left != '0) begin
            n_dv    = 1'b1;
            n_daddr = r_addr;
            n_dlast = (r_left == CNT_W'(1));
            n_addr  = slot_inc(r_addr);
            n_left  = r_left - 1'b1;
        end

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd        = i_item.cmd;
                    n_pid        = i_item.task_pid;
                    n_rs         = clean_state(i_item.task_state);
                    n_sp         = i_item.stack_ptr;
                    n_res_status = ST_OK;
                    n_res_sp     = '0;
                    n_dv         = 1'b0;
                    if (r_halted) begin
                        n_res_status = ST_NO_TASK;
                        n_state      = S_DONE;
                    end else begin
                        unique case (i_item.cmd) inside
                            CMD_ADD: begin
                                n_addr  = '0;
                                n_state = S_ADD;
                            end
                            CMD_KILL, CMD_SET: begin
                                n_addr  = '0;
                                n_left  = CNT_W'(NUM_SLOTS);
                                n_state = S_FIND;
                            end
                            CMD_TICK: begin
                                if (i_paused && r_valid[r_cur]) begin
                                    n_res_sp = i_item.stack_ptr;
                                    n_state  = S_DONE;
                                end else if (r_valid[r_cur]) begin
                                    n_addr  = r_cur;
                                    n_left  = CNT_W'(1);
                                    n_state = S_PREV;
                                end else begin
                                    n_addr  = slot_inc(r_cur);
                                    n_left  = CNT_W'(NUM_SLOTS);
                                    n_state = S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_ADD: begin
                if (!r_valid[r_addr]) begin
                    ram.pid_we      = 1'b1;
                    ram.rs_we       = 1'b1;
                    ram.rs_addr     = r_addr;
                    ram.rs_data     = r_rs;
                    ram.sp_we       = 1'b1;
                    n_valid[r_addr] = 1'b1;
                    n_state         = S_DONE;
                end else if (r_addr == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_addr = slot_inc(r_addr);
                end
            end
            S_FIND: begin
                if (r_dv) begin
                    if (r_valid[r_daddr] && i_rd_pid == r_pid) begin
                        if (r_cmd == CMD_KILL) begin
                            n_valid[r_daddr] = 1'b0;
                        end else begin
                            ram.rs_we   = 1'b1;
                            ram.rs_data = r_rs;
                        end
                        n_state = S_DONE;
                    end else if (r_dlast) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
            end
            S_PREV: begin
                if (r_dv) begin
                    if (i_rd_rs == RS_READY) begin
                        ram.rs_we = 1'b1;
                        n_run_pid = i_rd_pid;
                        n_res_sp  = i_rd_sp;
                        n_state   = S_DONE;
                    end else begin
                        n_addr  = slot_inc(r_cur);
                        n_left  = CNT_W'(NUM_SLOTS);
                        n_dv    = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                hit = r_dv && r_valid[r_daddr] && i_rd_rs != RS_BLOCKED;
                if (hit) begin
                    if (i_rd_rs == RS_READY && r_daddr == r_cur) begin
                        n_halted     = 1'b1;
                        n_res_status = ST_BAD_STATE;
                    end else begin
                        // save the interrupted pointer into the slot left behind
                        ram.sp_we   = r_valid[r_cur];
                        ram.sp_addr = r_cur;
                        ram.rs_we   = (i_rd_rs == RS_READY);
                        n_cur       = r_daddr;
                        n_run_pid   = i_rd_pid;
                        n_res_sp    = (r_daddr == r_cur) ? r_sp : i_rd_sp;
                    end
                    n_state = S_DONE;
                end else if (r_dv && r_dlast) begin
                    n_halted     = 1'b1;
                    n_res_status = ST_NO_TASK;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_sp     = r_res_sp;
                    n_out_pid    = r_run_pid;
                    n_out_slot   = CUR_SLOT_W'(r_cur);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cur       <= '0;
            r_run_pid   <= '0;
            r_halted    <= 1'b0;
            r_dv        <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cur       <= n_cur;
            r_run_pid   <= n_run_pid;
            r_halted    <= n_halted;
            r_dv        <= n_dv;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_daddr      <= n_daddr;
        r_dlast      <= n_dlast;
        r_cmd        <= n_cmd;
        r_pid        <= n_pid;
        r_rs         <= n_rs;
        r_sp         <= n_sp;
        r_res_status <= n_res_status;
        r_res_sp     <= n_res_sp;
        r_out_status <= n_out_status;
        r_out_sp     <= n_out_sp;
        r_out_pid    <= n_out_pid;
        r_out_slot   <= n_out_slot;
    end

    assign i_item.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.resume_sp    = r_out_sp;
    assign o_res.current_pid  = r_out_pid;
    assign o_res.current_slot = r_out_slot;
    assign o_ram              = ram;

endmodule

### sv/round_robin_task_scheduler.sv
// channel   dir   handshake      payload
// i_item    in    valid/ready    cmd, task_pid, task_state, stack_ptr
// o_res     out   valid/ready    status, resume_sp, current_pid, current_slot
// i_cfg     in    i_cfg_we       i_cfg_wdata (paused)
//
// one slot visited per cycle by a single scan counter over the slot rams
// add takes the first free slot from slot 0; kill and set state scan the table for the pid
// tick returns the item's pointer when held, else checks the current slot, then scans the table
// i_item.ready is low from acceptance until the result is in the output register
// a result waiting on o_res holds the next item in its last cycle
// synchronous active-low reset clears the table, current task, halt; paused resets to 1
module round_robin_task_scheduler import rrts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_in_if.sink    i_item,
    rrts_out_if.source o_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic             r_paused;
    t_ram_req         ram;
    logic [PID_W-1:0] rd_pid;
    logic [RS_W-1:0]  rd_rs;
    logic [SP_W-1:0]  rd_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused <= 1'b1;
        end else if (i_cfg_we) begin
            r_paused <= i_cfg_wdata;
        end
    end

    rrts_ram #(.WIDTH(PID_W), .DEPTH(NUM_SLOTS)) u_pid_ram (
        .i_clk     (i_clk),
        .i_we      (ram.pid_we),
        .i_wr_addr (ram.pid_addr),
        .i_wr_data (ram.pid_data),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_pid)
    );

    rrts_ram #(.WIDTH(RS_W), .DEPTH(NUM_SLOTS)) u_rs_ram (
        .i_clk     (i_clk),
        .i_we      (ram.rs_we),
        .i_wr_addr (ram.rs_addr),
        .i_wr_data (ram.rs_data),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_rs)
    );

    rrts_ram #(.WIDTH(SP_W), .DEPTH(NUM_SLOTS)) u_sp_ram (
        .i_clk     (i_clk),
        .i_we      (ram.sp_we),
        .i_wr_addr (ram.sp_addr),
        .i_wr_data (ram.sp_data),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_sp)
    );

    rrts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_paused (r_paused),
        .i_item   (i_item),
        .o_res    (o_res),
        .o_ram    (ram),
        .i_rd_pid (rd_pid),
        .i_rd_rs  (rd_rs),
        .i_rd_sp  (rd_sp)
    );

endmodule

### sv/rrts_chk.sv
module rrts_chk import rrts_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [STATUS_W-1:0]   i_status,
    input logic [SP_W-1:0]       i_resume_sp,
    input logic [PID_W-1:0]      i_current_pid,
    input logic [CUR_SLOT_W-1:0] i_current_slot
);

    logic r_seen_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (i_out_valid && i_out_ready &&
                     (i_status == ST_NO_TASK || i_status == ST_BAD_STATE)) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an item was accepted");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_BAD_STATE)
        else $error("status code out of range");

    a_error_no_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_resume_sp == '0)
        else $error("resume pointer nonzero on a failed item");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_halt |-> i_status == ST_NO_TASK)
        else $error("item answered after halt without halt status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_resume_sp) && $stable(i_current_pid) && $stable(i_current_slot))
        else $error("stalled result changed");

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_resume_sp    (o_res.resume_sp),
    .i_current_pid  (o_res.current_pid),
    .i_current_slot (o_res.current_slot)
);

### sim/tb.sv
module tb;
    import rrts_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 206;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_N        = 24;

    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_mix;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SP_W-1:0]       resume_sp;
        logic [PID_W-1:0]      current_pid;
        logic [CUR_SLOT_W-1:0] current_slot;
    } t_answer;

    typedef struct packed {
        logic             is_cfg;
        logic             cfg_val;
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] pid;
        logic [RS_W-1:0]  state;
        logic [SP_W-1:0]  sp;
        logic             typed;
        t_answer          want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{0, 0, CMD_ADD, 16'h0000, RS_READY, 32'hFFFF_FFFF, 1, '{ST_OK, 0, 16'h0000, 0}},
        '{0, 0, CMD_ADD, 16'hFFFF, RS_RUNNING, 32'h0000_0000, 1, '{ST_OK, 0, 16'h0000, 0}},
        '{0, 0, CMD_ADD, 16'h1234, RS_UNKNOWN, 32'hA5A5_A5A5, 1, '{ST_OK, 0, 16'h0000, 0}},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h1111_1111, 1,
          '{ST_OK, 32'h1111_1111, 16'h0000, 0}},
        '{1, 0, CMD_ADD, 16'h0000, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h2222_2222, 1,
          '{ST_OK, 32'hFFFF_FFFF, 16'h0000, 0}},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h3333_3333, 1, '{ST_OK, 0, 16'hFFFF, 1}},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h4444_4444, 1,
          '{ST_OK, 32'h3333_3333, 16'h0000, 0}},
        '{0, 0, CMD_SET, 16'h1234, RS_READY, 32'h0, 1, '{ST_OK, 0, 16'h0000, 0}},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h5555_5555, 0, '0},
        '{0, 0, CMD_KILL, 16'h4321, RS_READY, 32'h0, 1, '{ST_NOT_FOUND, 0, 16'hFFFF, 1}},
        '{0, 0, CMD_ADD, 16'hFFFF, RS_READY, 32'h6666_6666, 0, '0},
        '{0, 0, CMD_KILL, 16'hFFFF, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h7777_7777, 0, '0},
        '{1, 1, CMD_ADD, 16'h0000, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_KILL, 16'h1234, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h8888_8888, 0, '0},
        '{0, 0, CMD_SET, 16'hFFFF, RS_UNKNOWN, 32'h0, 0, '0},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'h0000_0000, 1, '{ST_OK, 0, 16'hFFFF, 3}},
        '{0, 0, CMD_SET, 16'h0000, RS_BLOCKED, 32'h0, 0, '0},
        '{1, 0, CMD_ADD, 16'h0000, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_ADD, 16'h0000, RS_RUNNING, 32'h1234_5678, 0, '0},
        '{0, 0, CMD_SET, 16'h0000, RS_READY, 32'h0, 0, '0},
        '{0, 0, CMD_TICK, 16'h0000, RS_READY, 32'hFFFF_FFFF, 0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    rrts_in_if  item_if ();
    rrts_out_if res_if ();

    round_robin_task_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predicted task table
    logic              tbl_used  [NUM_SLOTS];
    logic [PID_W-1:0]  tbl_pid   [NUM_SLOTS];
    logic [RS_W-1:0]   tbl_state [NUM_SLOTS];
    logic [SP_W-1:0]   tbl_sp    [NUM_SLOTS];
    logic [SLOT_W-1:0] run_slot;
    logic [PID_W-1:0]  run_pid;
    logic              halt_flag;
    logic              hold_cfg;

    t_answer answer_q [$];
    int      cmd_count [4];
    int      cfg_writes;
    int      n_err;
    int      n_results;
    int      n_full;
    int      n_missing;
    int      n_halt;
    int      cycles;
    int      send_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, answer_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int occupied();
        int n;
        int cnt;
        cnt = 0;
        for (n = 0; n < NUM_SLOTS; n++) begin
            if (tbl_used[n]) cnt++;
        end
        return cnt;
    endfunction

    task automatic predict_answer(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                                  input logic [RS_W-1:0] state, input logic [SP_W-1:0] sp,
                                  output t_answer ans);
        logic [RS_W-1:0]   st_n;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] pos;
        logic              found;
        int                hit;
        int                n;
        st_n = (state == RS_UNKNOWN) ? RS_BLOCKED : state;
        ans = '0;
        hit = -1;
        for (n = 0; n < NUM_SLOTS; n++) begin
            if (hit < 0 && tbl_used[n] && tbl_pid[n] == pid) hit = n;
        end
        if (halt_flag) begin
            ans.status = ST_NO_TASK;
        end else begin
            case (cmd)
                CMD_ADD: begin
                    ans.status = ST_FULL;
                    for (n = 0; n < NUM_SLOTS; n++) begin
                        if (!tbl_used[n] && ans.status == ST_FULL) begin
                            tbl_used[n]  = 1'b1;
                            tbl_pid[n]   = pid;
                            tbl_state[n] = st_n;
                            tbl_sp[n]    = sp;
                            ans.status   = ST_OK;
                        end
                    end
                end
                CMD_KILL: begin
                    if (hit < 0) ans.status = ST_NOT_FOUND;
                    else tbl_used[hit] = 1'b0;
                end
                CMD_SET: begin
                    if (hit < 0) ans.status = ST_NOT_FOUND;
                    else tbl_state[hit] = st_n;
                end
                default: begin
                    prev  = run_slot;
                    pos   = prev;
                    found = 1'b0;
                    if (hold_cfg && tbl_used[prev]) begin
                        ans.resume_sp = sp;
                    end else if (tbl_used[prev] && tbl_state[prev] == RS_READY) begin
                        tbl_state[prev] = RS_RUNNING;
                        run_pid         = tbl_pid[prev];
                        ans.resume_sp   = tbl_sp[prev];
                    end else begin
                        for (n = 0; n < NUM_SLOTS && !found; n++) begin
                            pos = (pos == SLOT_W'(NUM_SLOTS - 1)) ? '0 : pos + 1'b1;
                            if (tbl_used[pos] && tbl_state[pos] != RS_BLOCKED) found = 1'b1;
                        end
                        if (!found) begin
                            halt_flag  = 1'b1;
                            ans.status = ST_NO_TASK;
                        end else if (tbl_state[pos] == RS_READY && pos == prev) begin
                            halt_flag  = 1'b1;
                            ans.status = ST_BAD_STATE;
                        end else begin
                            if (tbl_used[prev]) tbl_sp[prev] = sp;
                            if (tbl_state[pos] == RS_READY) tbl_state[pos] = RS_RUNNING;
                            run_slot      = pos;
                            run_pid       = tbl_pid[pos];
                            ans.resume_sp = tbl_sp[pos];
                        end
                    end
                end
            endcase
        end
        ans.current_pid  = run_pid;
        ans.current_slot = CUR_SLOT_W'(run_slot);
    endtask

    function automatic int pick_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) send_calm = $urandom_range(40, 200);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [PID_W-1:0] any_pid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return PID_W'($urandom_range(0, 7));
        if (r < 72) return '1;
        if (r < 78) return '0;
        return PID_W'($urandom);
    endfunction

    task automatic random_item(input t_mix mix, output logic [CMD_W-1:0] cmd,
                               output logic [PID_W-1:0] pid, output logic [RS_W-1:0] state,
                               output logic [SP_W-1:0] sp);
        int   r;
        int   k;
        int   n;
        int   occ;
        int   add_w;
        int   kill_w;
        int   tick_w;
        logic live;
        occ    = occupied();
        add_w  = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 15 : 30;
        kill_w = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 40 : 20;
        tick_w = 30;
        r = $urandom_range(0, 99);
        if (r < add_w) cmd = CMD_ADD;
        else if (r < add_w + kill_w) cmd = CMD_KILL;
        else if (r < add_w + kill_w + tick_w) cmd = CMD_TICK;
        else cmd = CMD_SET;
        pid   = any_pid();
        state = RS_W'($urandom_range(0, 3));
        sp    = $urandom;
        if (cmd == CMD_ADD && $urandom_range(0, 1) == 1) state = RS_READY;
        if ((cmd == CMD_KILL || cmd == CMD_SET) && occ > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, occ - 1);
            for (n = 0; n < NUM_SLOTS; n++) begin
                if (tbl_used[n]) begin
                    if (k == 0) pid = tbl_pid[n];
                    k--;
                end
            end
        end
        // keep the halt for the closing part of the run
        live = hold_cfg && tbl_used[run_slot];
        for (n = 0; n < NUM_SLOTS; n++) begin
            if (tbl_used[n] && tbl_state[n] != RS_BLOCKED) live = 1'b1;
        end
        if (cmd == CMD_TICK && !live) begin
            if (occ < NUM_SLOTS) begin
                cmd   = CMD_ADD;
                state = RS_READY;
            end else begin
                cmd   = CMD_SET;
                pid   = tbl_pid[$urandom_range(0, NUM_SLOTS - 1)];
                state = ($urandom_range(0, 1) == 1) ? RS_RUNNING : RS_READY;
            end
        end
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                             input logic [RS_W-1:0] state, input logic [SP_W-1:0] sp,
                             input logic typed, input t_answer want);
        int      gap;
        t_answer pred;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.cmd        <= cmd;
        item_if.task_pid   <= pid;
        item_if.task_state <= state;
        item_if.stack_ptr  <= sp;
        item_if.valid      <= 1'b1;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        predict_answer(cmd, pid, state, sp, pred);
        answer_q.push_back(typed ? want : pred);
        cmd_count[cmd]++;
    endtask

    task automatic drain_answers();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_paused(input logic v);
        drain_answers();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        hold_cfg = v;
        cfg_writes++;
    endtask

    // result side back-pressure
    initial begin
        int stall;
        int calm;
        int r;
        stall = 0;
        calm  = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm > 0) begin
                calm--;
                res_if.ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 2) calm = $urandom_range(50, 300);
                else if (r < 25) stall = $urandom_range(1, 3);
                else if (r < 28) stall = $urandom_range(10, 50);
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.status       = res_if.status;
            got.resume_sp    = res_if.resume_sp;
            got.current_pid  = res_if.current_pid;
            got.current_slot = res_if.current_slot;
            n_results++;
            if (got.status == ST_FULL) n_full++;
            if (got.status == ST_NOT_FOUND) n_missing++;
            if (got.status == ST_NO_TASK || got.status == ST_BAD_STATE) n_halt++;
            if (answer_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected result: status %0d sp %h pid %h slot %0d",
                             got.status, got.resume_sp, got.current_pid, got.current_slot);
            end else begin
                want = answer_q.pop_front();
                if (got.status !== want.status || got.resume_sp !== want.resume_sp ||
                    got.current_pid !== want.current_pid ||
                    got.current_slot !== want.current_slot) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS) begin
                        $display("result %0d: expected status %0d sp %h pid %h slot %0d",
                                 n_results, want.status, want.resume_sp, want.current_pid,
                                 want.current_slot);
                        $display("result %0d: got status %0d sp %h pid %h slot %0d",
                                 n_results, got.status, got.resume_sp, got.current_pid,
                                 got.current_slot);
                    end
                end
            end
        end
    end

    initial begin
        int               i;
        int               p;
        int               j;
        t_mix             mix;
        t_dir_row         row;
        logic [CMD_W-1:0] c;
        logic [PID_W-1:0] pid;
        logic [RS_W-1:0]  st;
        logic [SP_W-1:0]  sp;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 1'b0;
        item_if.valid      = 1'b0;
        item_if.cmd        = CMD_ADD;
        item_if.task_pid   = '0;
        item_if.task_state = RS_READY;
        item_if.stack_ptr  = '0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_pid[i]   = '0;
            tbl_state[i] = RS_READY;
            tbl_sp[i]    = '0;
        end
        run_slot  = '0;
        run_pid   = '0;
        halt_flag = 1'b0;
        hold_cfg  = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            row = DIR_ROWS[i];
            if (row.is_cfg) write_paused(row.cfg_val);
            else send_item(row.cmd, row.pid, row.state, row.sp, row.typed, row.want);
        end

        for (p = 0; p < PHASES; p++) begin
            write_paused(p % 3 == 1);
            mix = t_mix'($urandom_range(0, 2));
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 2) drain_answers();
                random_item(mix, c, pid, st, sp);
                send_item(c, pid, st, sp, 1'b0, '0);
            end
        end

        // empty the table, then halt and check that the halt sticks
        write_paused(1'b0);
        while (occupied() != 0) begin
            j = -1;
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (j < 0 && tbl_used[i]) j = i;
            end
            send_item(CMD_KILL, tbl_pid[j], RS_READY, '0, 1'b0, '0);
        end
        send_item(CMD_TICK, any_pid(), RS_READY, $urandom, 1'b0, '0);
        send_item(CMD_ADD, any_pid(), RS_READY, $urandom, 1'b0, '0);
        send_item(CMD_TICK, any_pid(), RS_READY, $urandom, 1'b0, '0);
        send_item(CMD_KILL, any_pid(), RS_READY, $urandom, 1'b0, '0);
        send_item(CMD_SET, any_pid(), RS_RUNNING, $urandom, 1'b0, '0);
        drain_answers();
        repeat (30) @(posedge i_clk);

        $display("%0d items: %0d add, %0d kill, %0d tick, %0d set state; %0d pause writes",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], cmd_count[CMD_ADD],
                 cmd_count[CMD_KILL], cmd_count[CMD_TICK], cmd_count[CMD_SET], cfg_writes);
        $display("%0d results: %0d table full, %0d pid not found, %0d halted, %0d mismatches",
                 n_results, n_full, n_missing, n_halt, n_err);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
